FILE: src/lvs_pkg.sv
// shared types and constants of the line voltage supervisor
`default_nettype none

package lvs_pkg;

   localparam int MAX_LINES = 3;

   typedef enum logic [1:0] {
      ACT_VOLTAGE = 2'd0,
      ACT_TEMP    = 2'd1,
      ACT_COMMAND = 2'd2,
      ACT_STATUS  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      CMD_LINE_ON  = 4'd0,
      CMD_LINE_OFF = 4'd1,
      CMD_ALL_ON   = 4'd2,
      CMD_ALL_OFF  = 4'd3,
      CMD_DEV1_ON  = 4'd4,
      CMD_DEV1_OFF = 4'd5,
      CMD_DEV2_ON  = 4'd6,
      CMD_DEV2_OFF = 4'd7,
      CMD_DEV2_AUTO = 4'd8
   } command_type;

   typedef enum logic [2:0] {
      REG_LINE1_LOW  = 3'd0,
      REG_LINE1_HIGH = 3'd1,
      REG_LINE2_LOW  = 3'd2,
      REG_LINE2_HIGH = 3'd3,
      REG_LINE3_LOW  = 3'd4,
      REG_LINE3_HIGH = 3'd5,
      REG_RESTART    = 3'd6,
      REG_OVERTEMP   = 3'd7
   } reg_index_type;

   localparam logic [9:0] LINE1_LOW_RST  = 10'd690;
   localparam logic [9:0] LINE1_HIGH_RST = 10'd935;
   localparam logic [9:0] LINE2_LOW_RST  = 10'd715;
   localparam logic [9:0] LINE2_HIGH_RST = 10'd970;
   localparam logic [9:0] LINE3_LOW_RST  = 10'd700;
   localparam logic [9:0] LINE3_HIGH_RST = 10'd950;
   localparam logic [7:0] RESTART_RST    = 8'd15;
   localparam logic signed [11:0] OVERTEMP_RST = 12'sd720;

   // fan hysteresis thresholds, sixteenths of a degree
   localparam logic signed [11:0] FAN_OFF_BELOW = 12'sd256;
   localparam logic signed [11:0] FAN_ON_ABOVE  = 12'sd480;

   localparam int CSR_DATA_WIDTH = 12;

   typedef struct packed {
      logic [1:0]         action;
      logic [1:0]         line;
      logic [9:0]         sample;
      logic signed [11:0] temperature;
      logic               reading_valid;
      logic [3:0]         command;
   } req_type;

   typedef struct packed {
      logic [2:0]  line_relays;
      logic [1:0]  device_relays;
      logic [2:0]  line_enables;
      logic [15:0] downtime_one;
      logic [15:0] downtime_two;
      logic [15:0] downtime_three;
      logic        overtemp_alarm;
      logic        reclosed;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/lvs_stream_if.sv
// valid/ready channel carrying one item of a given payload type
`default_nettype none

interface lvs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: src/line_voltage_supervisor_core.sv
// line voltage supervisor: window check, restart delay, fan and overtemperature control
//
// Items arrive on req_if (voltage sample, temperature sample, command or status read)
// and each one gives exactly one item on rsp_if with relay, enable and counter state.
// The user writes registers through csr_wr_en / csr_index / csr_wdata only while the
// block is idle; the block does not enforce this. An item is decided in the cycle it is
// accepted: the line state and the result register are both loaded at that clock edge,
// so the result shows on rsp_if in the cycle after acceptance. One item per cycle is
// taken as long as the result register is empty or being emptied in that same cycle;
// the compare and count logic of each line sits between the input port and that register.
// When the receiver stalls, the result is held and req_if.ready drops until it is
// taken; no item is lost or repeated.
// Reset (synchronous) opens all relays, enables and arms all lines, clears the
// counters, turns both device relays off and reloads the register defaults.
// NUM_LINES sets how many lines are supervised; DOWNTIME_WIDTH sets the width of
// the saturating reclose counters, of which the low 16 bits are reported.
`default_nettype none

module line_voltage_supervisor_core #(
   parameter int NUM_LINES      = 3,
   parameter int DOWNTIME_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   lvs_stream_if.sink                               req_if,
   lvs_stream_if.source                             rsp_if,
   input  wire logic                                csr_wr_en,
   input  wire logic [2:0]                          csr_index,
   input  wire logic [lvs_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      DEV_OFF  = 2'd0,
      DEV_ON   = 2'd1,
      DEV_AUTO = 2'd2
   } dev_mode_type;

   localparam logic [2:0] LINE_LIMIT = 3'(NUM_LINES);
   localparam logic [DOWNTIME_WIDTH-1:0] DOWNTIME_MAX = '1;
   localparam logic [DOWNTIME_WIDTH-1:0] DOWNTIME_ONE = DOWNTIME_WIDTH'(1);

   // configuration
   logic [9:0]         low_ff  [lvs_pkg::MAX_LINES];
   logic [9:0]         high_ff [lvs_pkg::MAX_LINES];
   logic [7:0]         restart_ff;
   logic signed [11:0] overtemp_ff;

   // line state
   logic [NUM_LINES-1:0]      relay_ff, relay_in;
   logic [NUM_LINES-1:0]      enable_ff, enable_in;
   logic [NUM_LINES-1:0]      armed_ff, armed_in;
   logic [7:0]                good_ff [NUM_LINES];
   logic [7:0]                good_in [NUM_LINES];
   logic [DOWNTIME_WIDTH-1:0] downtime_ff [NUM_LINES];
   logic [DOWNTIME_WIDTH-1:0] downtime_in [NUM_LINES];

   // device state
   logic         dev1_relay_ff, dev1_relay_in;
   logic         dev2_relay_ff, dev2_relay_in;
   dev_mode_type dev2_mode_ff, dev2_mode_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   lvs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   lvs_pkg::req_type req;
   logic             accept;
   logic             line_ok;
   logic [7:0]       need;

   assign req            = req_if.payload;
   assign req_if.ready   = !rsp_valid_ff || rsp_if.ready;
   assign accept         = req_if.valid && req_if.ready;
   assign line_ok        = {1'b0, req.line} < LINE_LIMIT;
   assign need           = (restart_ff == 8'd0) ? 8'd1 : restart_ff;
   assign rsp_valid_in   = accept || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      logic [7:0]  cnt;
      logic        hit;
      logic        bad;
      logic        any_en;
      logic        over;
      logic        alarm;
      logic        recl;
      logic [31:0] dt_wide;
      logic [15:0] dt_out [lvs_pkg::MAX_LINES];

      relay_in      = relay_ff;
      enable_in     = enable_ff;
      armed_in      = armed_ff;
      good_in       = good_ff;
      downtime_in   = downtime_ff;
      dev1_relay_in = dev1_relay_ff;
      dev2_relay_in = dev2_relay_ff;
      dev2_mode_in  = dev2_mode_ff;
      alarm         = 1'b0;
      recl          = 1'b0;
      any_en        = |enable_ff;
      over          = req.temperature > overtemp_ff;
      cnt           = 8'd0;
      hit           = 1'b0;
      bad           = 1'b0;
      dt_wide       = '0;

      unique case (req.action)
         lvs_pkg::ACT_VOLTAGE: begin
            for (int i = 0; i < NUM_LINES; i++) begin
               hit = req.line == 2'(i);
               bad = (req.sample < low_ff[i]) || (req.sample > high_ff[i]) || !enable_ff[i];
               cnt = good_ff[i] + 8'd1;
               if (hit) begin
                  if (bad) begin
                     relay_in[i] = 1'b0;
                     armed_in[i] = 1'b1;
                     good_in[i]  = 8'd0;
                  end else if (armed_ff[i]) begin
                     if (cnt >= need) begin
                        relay_in[i] = 1'b1;
                        armed_in[i] = 1'b0;
                        good_in[i]  = 8'd0;
                        recl        = 1'b1;
                        if (downtime_ff[i] != DOWNTIME_MAX) begin
                           downtime_in[i] = downtime_ff[i] + DOWNTIME_ONE;
                        end
                     end else begin
                        good_in[i] = cnt;
                     end
                  end
               end
            end
         end
         lvs_pkg::ACT_TEMP: begin
            if (req.reading_valid) begin
               if (dev2_mode_ff == DEV_AUTO) begin
                  if (req.temperature < lvs_pkg::FAN_OFF_BELOW) begin
                     dev2_relay_in = 1'b0;
                  end else if (req.temperature > lvs_pkg::FAN_ON_ABOVE) begin
                     dev2_relay_in = 1'b1;
                  end
               end
               if (over && any_en) begin
                  relay_in  = '0;
                  armed_in  = '1;
                  enable_in = '0;
                  for (int i = 0; i < NUM_LINES; i++) good_in[i] = 8'd0;
                  alarm = 1'b1;
               end
            end
         end
         lvs_pkg::ACT_COMMAND: begin
            case (req.command)
               lvs_pkg::CMD_LINE_ON: begin
                  for (int i = 0; i < NUM_LINES; i++) begin
                     if (req.line == 2'(i)) enable_in[i] = 1'b1;
                  end
               end
               lvs_pkg::CMD_LINE_OFF: begin
                  for (int i = 0; i < NUM_LINES; i++) begin
                     if (req.line == 2'(i)) begin
                        relay_in[i]  = 1'b0;
                        armed_in[i]  = 1'b1;
                        good_in[i]   = 8'd0;
                        enable_in[i] = 1'b0;
                     end
                  end
               end
               lvs_pkg::CMD_ALL_ON: enable_in = '1;
               lvs_pkg::CMD_ALL_OFF: begin
                  relay_in  = '0;
                  armed_in  = '1;
                  enable_in = '0;
                  for (int i = 0; i < NUM_LINES; i++) good_in[i] = 8'd0;
               end
               lvs_pkg::CMD_DEV1_ON:  dev1_relay_in = 1'b1;
               lvs_pkg::CMD_DEV1_OFF: dev1_relay_in = 1'b0;
               lvs_pkg::CMD_DEV2_ON: begin
                  dev2_mode_in  = DEV_ON;
                  dev2_relay_in = 1'b1;
               end
               lvs_pkg::CMD_DEV2_OFF: begin
                  dev2_mode_in  = DEV_OFF;
                  dev2_relay_in = 1'b0;
               end
               lvs_pkg::CMD_DEV2_AUTO: begin
                  dev2_mode_in  = DEV_AUTO;
                  dev2_relay_in = 1'b1;
               end
               default: ;
            endcase
         end
         lvs_pkg::ACT_STATUS: begin
            for (int i = 0; i < NUM_LINES; i++) downtime_in[i] = '0;
         end
         default: ;
      endcase

      // status read reports the counters as they were before clearing
      for (int i = 0; i < lvs_pkg::MAX_LINES; i++) dt_out[i] = 16'd0;
      for (int i = 0; i < NUM_LINES; i++) begin
         dt_wide   = (req.action == lvs_pkg::ACT_STATUS) ? 32'(downtime_ff[i])
                                                         : 32'(downtime_in[i]);
         dt_out[i] = dt_wide[15:0];
      end

      rsp_data_in                = '0;
      rsp_data_in.line_relays    = 3'(relay_in);
      rsp_data_in.line_enables   = 3'(enable_in);
      rsp_data_in.device_relays  = {dev2_relay_in, dev1_relay_in};
      rsp_data_in.downtime_one   = dt_out[0];
      rsp_data_in.downtime_two   = dt_out[1];
      rsp_data_in.downtime_three = dt_out[2];
      rsp_data_in.overtemp_alarm = alarm;
      rsp_data_in.reclosed       = recl && line_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff[0]   <= lvs_pkg::LINE1_LOW_RST;
         high_ff[0]  <= lvs_pkg::LINE1_HIGH_RST;
         low_ff[1]   <= lvs_pkg::LINE2_LOW_RST;
         high_ff[1]  <= lvs_pkg::LINE2_HIGH_RST;
         low_ff[2]   <= lvs_pkg::LINE3_LOW_RST;
         high_ff[2]  <= lvs_pkg::LINE3_HIGH_RST;
         restart_ff  <= lvs_pkg::RESTART_RST;
         overtemp_ff <= lvs_pkg::OVERTEMP_RST;
      end else if (csr_wr_en) begin
         unique case (lvs_pkg::reg_index_type'(csr_index))
            lvs_pkg::REG_LINE1_LOW:  low_ff[0]   <= csr_wdata[9:0];
            lvs_pkg::REG_LINE1_HIGH: high_ff[0]  <= csr_wdata[9:0];
            lvs_pkg::REG_LINE2_LOW:  low_ff[1]   <= csr_wdata[9:0];
            lvs_pkg::REG_LINE2_HIGH: high_ff[1]  <= csr_wdata[9:0];
            lvs_pkg::REG_LINE3_LOW:  low_ff[2]   <= csr_wdata[9:0];
            lvs_pkg::REG_LINE3_HIGH: high_ff[2]  <= csr_wdata[9:0];
            lvs_pkg::REG_RESTART:    restart_ff  <= csr_wdata[7:0];
            lvs_pkg::REG_OVERTEMP:   overtemp_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff      <= '0;
         enable_ff     <= '1;
         armed_ff      <= '1;
         dev1_relay_ff <= 1'b0;
         dev2_relay_ff <= 1'b0;
         dev2_mode_ff  <= DEV_OFF;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_LINES; i++) begin
            good_ff[i]     <= 8'd0;
            downtime_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            relay_ff      <= relay_in;
            enable_ff     <= enable_in;
            armed_ff      <= armed_in;
            dev1_relay_ff <= dev1_relay_in;
            dev2_relay_ff <= dev2_relay_in;
            dev2_mode_ff  <= dev2_mode_in;
            good_ff       <= good_in;
            downtime_ff   <= downtime_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// self-checking testbench for the line voltage supervisor core
`timescale 1ns / 1ps

module tb;

   localparam int LINES = 3;
   localparam logic [3:0] CMD_UNKNOWN_LOW  = 4'd9;
   localparam logic [3:0] CMD_UNKNOWN_HIGH = 4'd15;

   typedef enum logic [1:0] {
      FAN_FORCED_OFF = 2'd0,
      FAN_FORCED_ON  = 2'd1,
      FAN_AUTO       = 2'd2
   } fan_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [2:0] csr_index;
   logic [lvs_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   lvs_stream_if #(.payload_type(lvs_pkg::req_type)) req_ch ();
   lvs_stream_if #(.payload_type(lvs_pkg::rsp_type)) rsp_ch ();

   line_voltage_supervisor_core #(
      .NUM_LINES      (LINES),
      .DOWNTIME_WIDTH (16)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // mirror of the register file and the line state
   logic [9:0] win_low [LINES];
   logic [9:0] win_high [LINES];
   logic [7:0] restart_need;
   logic signed [11:0] overtemp_lim;
   logic [LINES-1:0] relay_closed, line_enabled, line_armed;
   logic [7:0] good_run [LINES];
   logic [15:0] reclose_count [LINES];
   logic dev1_relay, dev2_relay;
   fan_mode_type fan_mode;

   lvs_pkg::rsp_type pending_status[$];
   int status_errors = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int hold_len = 0;

   function automatic void reset_model();
      win_low[0] = lvs_pkg::LINE1_LOW_RST;
      win_high[0] = lvs_pkg::LINE1_HIGH_RST;
      win_low[1] = lvs_pkg::LINE2_LOW_RST;
      win_high[1] = lvs_pkg::LINE2_HIGH_RST;
      win_low[2] = lvs_pkg::LINE3_LOW_RST;
      win_high[2] = lvs_pkg::LINE3_HIGH_RST;
      restart_need = lvs_pkg::RESTART_RST;
      overtemp_lim = lvs_pkg::OVERTEMP_RST;
      relay_closed = '0;
      line_enabled = '1;
      line_armed = '1;
      for (int i = 0; i < LINES; i++) begin
         good_run[i] = '0;
         reclose_count[i] = '0;
      end
      dev1_relay = 1'b0;
      dev2_relay = 1'b0;
      fan_mode = FAN_FORCED_OFF;
   endfunction

   function automatic void open_line(input int ln);
      relay_closed[ln] = 1'b0;
      line_armed[ln] = 1'b1;
      good_run[ln] = '0;
   endfunction

   function automatic lvs_pkg::rsp_type line_snapshot(input logic alarm, input logic recl);
      lvs_pkg::rsp_type s;
      s.line_relays = relay_closed;
      s.device_relays = {dev2_relay, dev1_relay};
      s.line_enables = line_enabled;
      s.downtime_one = reclose_count[0];
      s.downtime_two = reclose_count[1];
      s.downtime_three = reclose_count[2];
      s.overtemp_alarm = alarm;
      s.reclosed = recl;
      return s;
   endfunction

   // advances the mirror by one item and returns the status it should report
   function automatic lvs_pkg::rsp_type supervise(input lvs_pkg::req_type r);
      lvs_pkg::rsp_type s;
      logic alarm, recl;
      logic [7:0] need;
      logic signed [11:0] temp;
      int ln;
      alarm = 1'b0;
      recl = 1'b0;
      ln = r.line;
      temp = $signed(r.temperature);
      case (lvs_pkg::action_type'(r.action))
         lvs_pkg::ACT_VOLTAGE: begin
            if (ln < LINES) begin
               if (r.sample < win_low[ln] || r.sample > win_high[ln] || !line_enabled[ln]) begin
                  open_line(ln);
               end else if (line_armed[ln]) begin
                  need = (restart_need == 8'd0) ? 8'd1 : restart_need;
                  good_run[ln] = good_run[ln] + 8'd1;
                  if (good_run[ln] >= need) begin
                     relay_closed[ln] = 1'b1;
                     line_armed[ln] = 1'b0;
                     good_run[ln] = '0;
                     if (reclose_count[ln] != 16'hFFFF)
                        reclose_count[ln] = reclose_count[ln] + 16'd1;
                     recl = 1'b1;
                  end
               end
            end
         end
         lvs_pkg::ACT_TEMP: begin
            if (r.reading_valid) begin
               if (fan_mode == FAN_AUTO) begin
                  if (temp < lvs_pkg::FAN_OFF_BELOW)
                     dev2_relay = 1'b0;
                  else if (temp > lvs_pkg::FAN_ON_ABOVE)
                     dev2_relay = 1'b1;
               end
               // shutdown only counts while some line is still enabled
               if (temp > overtemp_lim && line_enabled != '0) begin
                  for (int i = 0; i < LINES; i++) begin
                     open_line(i);
                     line_enabled[i] = 1'b0;
                  end
                  alarm = 1'b1;
               end
            end
         end
         lvs_pkg::ACT_COMMAND: begin
            case (r.command)
               lvs_pkg::CMD_LINE_ON: if (ln < LINES) line_enabled[ln] = 1'b1;
               lvs_pkg::CMD_LINE_OFF: begin
                  if (ln < LINES) begin
                     open_line(ln);
                     line_enabled[ln] = 1'b0;
                  end
               end
               lvs_pkg::CMD_ALL_ON: line_enabled = '1;
               lvs_pkg::CMD_ALL_OFF: begin
                  for (int i = 0; i < LINES; i++) begin
                     open_line(i);
                     line_enabled[i] = 1'b0;
                  end
               end
               lvs_pkg::CMD_DEV1_ON: dev1_relay = 1'b1;
               lvs_pkg::CMD_DEV1_OFF: dev1_relay = 1'b0;
               lvs_pkg::CMD_DEV2_ON: begin
                  fan_mode = FAN_FORCED_ON;
                  dev2_relay = 1'b1;
               end
               lvs_pkg::CMD_DEV2_OFF: begin
                  fan_mode = FAN_FORCED_OFF;
                  dev2_relay = 1'b0;
               end
               lvs_pkg::CMD_DEV2_AUTO: begin
                  fan_mode = FAN_AUTO;
                  dev2_relay = 1'b1;
               end
               default: ;
            endcase
         end
         default: begin
            // status read reports the counters, then clears them
            s = line_snapshot(1'b0, 1'b0);
            for (int i = 0; i < LINES; i++) reclose_count[i] = '0;
            return s;
         end
      endcase
      return line_snapshot(alarm, recl);
   endfunction

   function automatic void compare_status(input lvs_pkg::rsp_type got);
      lvs_pkg::rsp_type want;
      if (pending_status.size() == 0) begin
         status_errors++;
         if (status_errors <= 10)
            $display("%0t: status item with nothing pending: %p", $realtime, got);
         return;
      end
      want = pending_status.pop_front();
      if (got.line_relays !== want.line_relays || got.device_relays !== want.device_relays ||
          got.line_enables !== want.line_enables || got.downtime_one !== want.downtime_one ||
          got.downtime_two !== want.downtime_two || got.downtime_three !== want.downtime_three ||
          got.overtemp_alarm !== want.overtemp_alarm || got.reclosed !== want.reclosed) begin
         status_errors++;
         if (status_errors <= 10) begin
            $display("%0t: status expected %p", $realtime, want);
            $display("%0t: status actual   %p", $realtime, got);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         compare_status(rsp_ch.payload);
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_len > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_len = hold_len - 1;
      end else begin
         rsp_ch.ready <= !(rsp_idle_on && $urandom_range(99) < 32);
      end
   end

   // entered and left at a falling edge; valid stays high for a following item
   task automatic send_item(input lvs_pkg::req_type item);
      while (req_idle_on && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      pending_status.push_back(supervise(item));
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain_status();
      while (pending_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_settings(input int l1lo, input int l1hi, input int l2lo, input int l2hi,
                                input int l3lo, input int l3hi, input int need, input int limit);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         case (lvs_pkg::reg_index_type'(i))
            lvs_pkg::REG_LINE1_LOW: begin
               csr_wdata <= 12'(l1lo);
               win_low[0] = 10'(l1lo);
            end
            lvs_pkg::REG_LINE1_HIGH: begin
               csr_wdata <= 12'(l1hi);
               win_high[0] = 10'(l1hi);
            end
            lvs_pkg::REG_LINE2_LOW: begin
               csr_wdata <= 12'(l2lo);
               win_low[1] = 10'(l2lo);
            end
            lvs_pkg::REG_LINE2_HIGH: begin
               csr_wdata <= 12'(l2hi);
               win_high[1] = 10'(l2hi);
            end
            lvs_pkg::REG_LINE3_LOW: begin
               csr_wdata <= 12'(l3lo);
               win_low[2] = 10'(l3lo);
            end
            lvs_pkg::REG_LINE3_HIGH: begin
               csr_wdata <= 12'(l3hi);
               win_high[2] = 10'(l3hi);
            end
            lvs_pkg::REG_RESTART: begin
               csr_wdata <= 12'(need);
               restart_need = 8'(need);
            end
            default: begin
               csr_wdata <= 12'(limit);
               overtemp_lim = 12'(limit);
            end
         endcase
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic lvs_pkg::req_type make_request(input lvs_pkg::action_type act,
                                                     input int ln, input int smp,
                                                     input int temp, input bit ok,
                                                     input logic [3:0] cmd);
      lvs_pkg::req_type r;
      r.action = act;
      r.line = 2'(ln);
      r.sample = 10'(smp);
      r.temperature = 12'(temp);
      r.reading_valid = ok;
      r.command = cmd;
      return r;
   endfunction

   // mostly in-window samples on supervised lines so that recloses happen
   function automatic lvs_pkg::req_type random_request();
      lvs_pkg::req_type r;
      int pick, ln, t;
      r.action = 2'($urandom_range(3));
      r.line = 2'($urandom_range(3));
      r.sample = 10'($urandom_range(1023));
      r.temperature = 12'($urandom_range(4095));
      r.reading_valid = 1'($urandom_range(1));
      r.command = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 60) begin
         r.action = lvs_pkg::ACT_VOLTAGE;
         if ($urandom_range(19) != 0) r.line = 2'($urandom_range(LINES - 1));
         ln = r.line;
         if (ln < LINES) begin
            case ($urandom_range(9))
               0, 1: ;
               2: r.sample = $urandom_range(1) ? win_low[ln] - 10'd1 : win_high[ln] + 10'd1;
               default: begin
                  if (win_low[ln] <= win_high[ln])
                     r.sample = 10'($urandom_range(win_high[ln], win_low[ln]));
               end
            endcase
         end
      end else if (pick < 75) begin
         r.action = lvs_pkg::ACT_TEMP;
         r.reading_valid = ($urandom_range(9) != 0);
         t = int'($urandom_range(340)) + 200;
         case ($urandom_range(7))
            0, 1, 2: ;
            3: t = ($urandom_range(1) ? 256 : 480) + int'($urandom_range(6)) - 3;
            4, 5: t = int'(overtemp_lim) + int'($urandom_range(6)) - 3;
            6: t = int'($urandom_range(2880)) - 880;
            default: t = int'($signed(r.temperature));
         endcase
         r.temperature = 12'(t);
      end else if (pick < 90) begin
         r.action = lvs_pkg::ACT_COMMAND;
         if ($urandom_range(9) < 4)
            r.command = $urandom_range(1) ? lvs_pkg::CMD_ALL_ON : lvs_pkg::CMD_LINE_ON;
      end else begin
         r.action = lvs_pkg::ACT_STATUS;
      end
      return r;
   endfunction

   task automatic test_directed();
      send_item(make_request(lvs_pkg::ACT_STATUS, 0, 0, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 0, 0, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 0, 1023, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 3, 800, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 0, 690, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 0, 935, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_TEMP, 0, 0, 2047, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 1, 0, 0, 0, lvs_pkg::CMD_LINE_OFF));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 1, 800, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 1, 0, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 3, 0, 0, 0, lvs_pkg::CMD_LINE_OFF));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 0, 0, 0, 0, lvs_pkg::CMD_DEV1_ON));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 0, 0, 0, 0, lvs_pkg::CMD_DEV1_OFF));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 0, 0, 0, 0, lvs_pkg::CMD_DEV2_ON));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 0, 0, 0, 0, lvs_pkg::CMD_DEV2_OFF));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 0, 0, 0, 0, lvs_pkg::CMD_DEV2_AUTO));
      // fan hysteresis: off below, hold between, on above
      send_item(make_request(lvs_pkg::ACT_TEMP, 0, 0, 100, 1, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_TEMP, 0, 0, 300, 1, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_TEMP, 0, 0, 600, 1, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_TEMP, 0, 0, 720, 1, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_TEMP, 0, 0, 721, 1, lvs_pkg::CMD_LINE_ON));
      // no line left enabled, so no second shutdown
      send_item(make_request(lvs_pkg::ACT_TEMP, 0, 0, 2047, 1, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 0, 0, 0, 0, lvs_pkg::CMD_ALL_ON));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 0, 0, 0, 0, lvs_pkg::CMD_ALL_OFF));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 2, 0, 0, 0, CMD_UNKNOWN_LOW));
      send_item(make_request(lvs_pkg::ACT_COMMAND, 2, 0, -2048, 1, CMD_UNKNOWN_HIGH));
      stop_sending();
      drain_status();
   endtask

   task automatic test_restart_windows();
      // widest window, inverted window, restart count of zero
      load_settings(0, 1023, 600, 500, 700, 950, 0, 2000);
      send_item(make_request(lvs_pkg::ACT_COMMAND, 0, 0, 0, 0, lvs_pkg::CMD_ALL_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 0, 0, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 0, 1023, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 1, 550, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 2, 1023, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_VOLTAGE, 2, 800, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_STATUS, 0, 0, 0, 0, lvs_pkg::CMD_LINE_ON));
      send_item(make_request(lvs_pkg::ACT_STATUS, 0, 0, 0, 0, lvs_pkg::CMD_LINE_ON));
      stop_sending();
      drain_status();
   endtask

   task automatic test_random_traffic();
      int lo [LINES];
      int hi [LINES];
      for (int phase = 0; phase < 7; phase++) begin
         for (int i = 0; i < LINES; i++) begin
            lo[i] = $urandom_range(900);
            hi[i] = lo[i] + int'($urandom_range(123));
         end
         case (phase)
            0: load_settings(lvs_pkg::LINE1_LOW_RST, lvs_pkg::LINE1_HIGH_RST,
                             lvs_pkg::LINE2_LOW_RST, lvs_pkg::LINE2_HIGH_RST,
                             lvs_pkg::LINE3_LOW_RST, lvs_pkg::LINE3_HIGH_RST, 3,
                             lvs_pkg::OVERTEMP_RST);
            1: load_settings(0, 1023, 0, 1023, 0, 1023, 1, 2000);
            2: load_settings(lo[0], hi[0], 0, 1023, lo[2], hi[2], 255, -880);
            3: load_settings(lo[0], hi[0], 1023, 0, lo[2], hi[2], 0, 1500);
            default: load_settings(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2],
                                   $urandom_range(6, 1), $urandom_range(2000, 400));
         endcase
         repeat (110) send_item(random_request());
         stop_sending();
         drain_status();
      end
   endtask

   task automatic test_streaming();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      load_settings(650, 980, 650, 980, 650, 980, 2, 1200);
      repeat (200) send_item(random_request());
      stop_sending();
      drain_status();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      req_idle_on = 1'b0;
      @(posedge clock);
      hold_len = 80;
      @(negedge clock);
      repeat (30) send_item(random_request());
      stop_sending();
      // sender waits for every status before going on
      drain_status();
      repeat (20) send_item(random_request());
      stop_sending();
      drain_status();
      req_idle_on = 1'b1;
   endtask

   initial begin
      #2_000_000;
      $display("line_voltage_supervisor_core: mismatch");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset_model();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_restart_windows();
      test_random_traffic();
      test_streaming();
      test_backpressure();
      repeat (8) @(negedge clock);
      if (status_errors == 0 && pending_status.size() == 0)
         $display("line_voltage_supervisor_core: match");
      else
         $display("line_voltage_supervisor_core: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
src/lvs_pkg.sv
src/lvs_stream_if.sv
src/line_voltage_supervisor_core.sv
dv/tb.sv
